>>> hw/rtl/srap_pkg.sv
// shared constants for the scaled residual add and permute block
package srap_pkg;

  localparam int unsigned NST         = 5;   // register stages from input to output
  localparam int unsigned ADDR_W      = 11;
  localparam int unsigned BF_W        = 16;
  localparam int unsigned F32_W       = 32;
  localparam int unsigned TILE_W      = 3;
  localparam int unsigned ELEM_W      = 8;

  localparam int unsigned DEF_ROWS_PER_RUN = 4;
  localparam int unsigned DEF_TILE_K       = 8;
  localparam int unsigned DEF_TILE_N       = 64;

  localparam logic [F32_W-1:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [F32_W-1:0] F32_QNAN    = 32'hFFC0_0000;

  typedef logic [NST-1:0] stage_en_t;

endpackage

>>> hw/rtl/srap_fp_pipe.sv
// five stage bf16 multiply and f32 add datapath
module srap_fp_pipe
  import srap_pkg::*;
(
  input  logic             clk_i,
  input  stage_en_t        en_i,
  input  logic [BF_W-1:0]  scale_i,
  input  logic [BF_W-1:0]  a_i,
  input  logic [BF_W-1:0]  b_i,
  output logic [F32_W-1:0] value_o
);

  function automatic logic [4:0] lzc16(input logic [15:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd16;
    hit = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 5'(15 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd27;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 5'(26 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // stage 1: unpack and multiply significands
  logic        s_nan, s_inf, s_zero, b_nan, b_inf, b_zero, p_sign;
  logic [7:0]  ma, mb;
  logic [8:0]  ea, eb;
  logic        spec1_d;
  logic [31:0] sv1_d;
  logic [15:0] p1_q;
  logic [8:0]  e1_q;
  logic        sg1_q, spec1_q;
  logic [31:0] sv1_q;
  logic [15:0] a1_q;

  always_comb begin
    s_nan  = (&scale_i[14:7]) && (|scale_i[6:0]);
    s_inf  = (&scale_i[14:7]) && !(|scale_i[6:0]);
    s_zero = !(|scale_i[14:0]);
    b_nan  = (&b_i[14:7]) && (|b_i[6:0]);
    b_inf  = (&b_i[14:7]) && !(|b_i[6:0]);
    b_zero = !(|b_i[14:0]);
    p_sign = scale_i[15] ^ b_i[15];
    ma     = {|scale_i[14:7], scale_i[6:0]};
    mb     = {|b_i[14:7], b_i[6:0]};
    ea     = (scale_i[14:7] == 8'd0) ? 9'd1 : {1'b0, scale_i[14:7]};
    eb     = (b_i[14:7] == 8'd0) ? 9'd1 : {1'b0, b_i[14:7]};
    spec1_d = 1'b1;
    sv1_d   = '0;
    priority if (s_nan) begin
      sv1_d = {scale_i | 16'h0040, 16'h0000};
    end else if (b_nan) begin
      sv1_d = {b_i | 16'h0040, 16'h0000};
    end else if ((s_inf && b_zero) || (b_inf && s_zero)) begin
      sv1_d = F32_QNAN;
    end else if (s_inf || b_inf) begin
      sv1_d = {p_sign, 8'hFF, 23'd0};
    end else if (s_zero || b_zero) begin
      sv1_d = {p_sign, 31'd0};
    end else begin
      spec1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q    <= ma * mb;
      e1_q    <= ea + eb;
      sg1_q   <= p_sign;
      spec1_q <= spec1_d;
      sv1_q   <= sv1_d;
      a1_q    <= a_i;
    end
  end

  // stage 2: normalise the product into f32, rounding only in the subnormal range
  logic [4:0]         lz2;
  logic [4:0]         k2;
  logic signed [11:0] ex2;
  logic [23:0]        nm2;
  logic [6:0]         rsh2;
  logic [33:0]        rx2;
  logic [15:0]        rq2;
  logic               rup2;
  logic [31:0]        prod2_d;
  logic [31:0]        prod2_q;
  logic [15:0]        a2_q;

  always_comb begin
    lz2  = lzc16(p1_q);
    k2   = 5'd15 - lz2;
    ex2  = $signed({3'b000, e1_q}) + $signed({7'd0, k2}) - 12'sd141;
    nm2  = '0;
    rsh2 = '0;
    rx2  = '0;
    rq2  = '0;
    rup2 = 1'b0;
    priority if (spec1_q) begin
      prod2_d = sv1_q;
    end else if (ex2 >= 12'sd255) begin
      prod2_d = {sg1_q, 8'hFF, 23'd0};
    end else if (ex2 >= 12'sd1) begin
      nm2     = {8'd0, p1_q} << (5'd23 - k2);
      prod2_d = {sg1_q, ex2[7:0], nm2[22:0]};
    end else if (e1_q >= 9'd119) begin
      nm2     = {8'd0, p1_q} << (e1_q - 9'd119);
      prod2_d = {sg1_q, 8'd0, nm2[22:0]};
    end else begin
      // subnormal product: shift right with round to nearest even
      rsh2    = 7'(9'd119 - e1_q);
      rx2     = {p1_q, 18'd0} >> ((rsh2 > 7'd18) ? 7'd18 : rsh2);
      rq2     = rx2[33:18];
      rup2    = rx2[17] && ((|rx2[16:0]) || rq2[0]);
      prod2_d = {sg1_q, 8'd0, 7'd0, rq2} + {31'd0, rup2};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod2_q <= prod2_d;
      a2_q    <= a1_q;
    end
  end

  // stage 3: order operands by magnitude and align the smaller one
  logic [31:0] x3, y3, big3, sml3;
  logic        x_nan, y_nan, x_inf, y_inf, swap3;
  logic [7:0]  eb3, es3, d3;
  logic [26:0] t3;
  logic [53:0] f3;
  logic        spec3_d;
  logic [31:0] sv3_d;
  logic [23:0] bs3_q;
  logic [26:0] ss3_q;
  logic [7:0]  e3_q;
  logic        sg3_q, sub3_q, spec3_q;
  logic [31:0] sv3_q;

  always_comb begin
    x3    = {a2_q, 16'h0000};
    y3    = prod2_q;
    x_nan = (&x3[30:23]) && (|x3[22:0]);
    y_nan = (&y3[30:23]) && (|y3[22:0]);
    x_inf = (&x3[30:23]) && !(|x3[22:0]);
    y_inf = (&y3[30:23]) && !(|y3[22:0]);
    swap3 = y3[30:0] > x3[30:0];
    big3  = swap3 ? y3 : x3;
    sml3  = swap3 ? x3 : y3;
    eb3   = (big3[30:23] == 8'd0) ? 8'd1 : big3[30:23];
    es3   = (sml3[30:23] == 8'd0) ? 8'd1 : sml3[30:23];
    d3    = eb3 - es3;
    t3    = {|sml3[30:23], sml3[22:0], 3'b000};
    f3    = {t3, 27'd0} >> ((d3 > 8'd27) ? 8'd27 : d3);
    spec3_d = 1'b1;
    sv3_d   = '0;
    priority if (x_nan) begin
      sv3_d = x3 | 32'h0040_0000;
    end else if (y_nan) begin
      sv3_d = y3 | 32'h0040_0000;
    end else if (x_inf && y_inf && (x3[31] != y3[31])) begin
      sv3_d = F32_QNAN;
    end else if (x_inf) begin
      sv3_d = x3;
    end else if (y_inf) begin
      sv3_d = y3;
    end else begin
      spec3_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      bs3_q   <= {|big3[30:23], big3[22:0]};
      ss3_q   <= {f3[53:28], f3[27] | (|f3[26:0])};
      e3_q    <= eb3;
      sg3_q   <= big3[31];
      sub3_q  <= x3[31] ^ y3[31];
      spec3_q <= spec3_d;
      sv3_q   <= sv3_d;
    end
  end

  // stage 4: add or subtract significands
  logic [27:0] sum4_q;
  logic [7:0]  e4_q;
  logic        sg4_q, sub4_q, spec4_q;
  logic [31:0] sv4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      sum4_q  <= sub3_q ? ({1'b0, bs3_q, 3'b000} - {1'b0, ss3_q})
                        : ({1'b0, bs3_q, 3'b000} + {1'b0, ss3_q});
      e4_q    <= e3_q;
      sg4_q   <= sg3_q;
      sub4_q  <= sub3_q;
      spec4_q <= spec3_q;
      sv4_q   <= sv3_q;
    end
  end

  // stage 5: normalise, round to nearest even, pack
  logic [4:0]  lz5, sh5;
  logic [26:0] m5;
  logic [8:0]  ex5;
  logic        up5;
  logic [30:0] pk5;
  logic [31:0] res5_d;
  logic [31:0] res5_q;

  always_comb begin
    lz5 = lzc27(sum4_q[26:0]);
    sh5 = '0;
    m5  = '0;
    ex5 = '0;
    up5 = 1'b0;
    pk5 = '0;
    if (sum4_q[27]) begin
      m5  = {sum4_q[27:2], sum4_q[1] | sum4_q[0]};
      ex5 = {1'b0, e4_q} + 9'd1;
    end else if ({3'b000, lz5} < e4_q) begin
      m5  = sum4_q[26:0] << lz5;
      ex5 = {1'b0, e4_q} - {4'd0, lz5};
    end else begin
      // result lands in the subnormal range
      sh5 = 5'(e4_q - 8'd1);
      m5  = sum4_q[26:0] << sh5;
      ex5 = '0;
    end
    up5 = m5[2] && ((|m5[1:0]) || m5[3]);
    pk5 = {ex5[7:0], m5[25:3]} + {30'd0, up5};
    priority if (spec4_q) begin
      res5_d = sv4_q;
    end else if (sum4_q == 28'd0) begin
      res5_d = {sub4_q ? 1'b0 : sg4_q, 31'd0};
    end else if (ex5 >= 9'd255) begin
      res5_d = {sg4_q, 8'hFF, 23'd0};
    end else begin
      res5_d = {sg4_q, pk5};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      res5_q <= res5_d;
    end
  end

  assign value_o = res5_q;

endmodule

>>> hw/rtl/scaled_residual_add_permute.sv
// top level: c = a + scale*b in f32 with permuted c tile slot
//
//  channel | direction | handshake                 | payload
//  in      | in        | in_valid_i / in_stall_o   | a_value_i, b_value_i, tile_index_i,
//          |           |                           | element_index_i
//  out     | out       | out_valid_o / out_stall_i | c_address_o, c_value_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (scale word)
//
// one request per cycle sustained while out_stall_i is low; a result is offered
// from the last of the five register stages of the float datapath
// reset clears the stage valid bits and loads the scale register with 1.0
// each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and a stalled output holds without loss
module scaled_residual_add_permute
  import srap_pkg::*;
#(
  parameter int unsigned ROWS_PER_RUN = DEF_ROWS_PER_RUN,
  parameter int unsigned TILE_K       = DEF_TILE_K,
  parameter int unsigned TILE_N       = DEF_TILE_N
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BF_W-1:0]   a_value_i,
  input  logic [BF_W-1:0]   b_value_i,
  input  logic [TILE_W-1:0] tile_index_i,
  input  logic [ELEM_W-1:0] element_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ADDR_W-1:0] c_address_o,
  output logic [F32_W-1:0]  c_value_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [F32_W-1:0]  cfg_data_i
);

  localparam int unsigned RUN_LEN    = ROWS_PER_RUN * TILE_K;
  localparam int unsigned RUN_STRIDE = TILE_N * ROWS_PER_RUN;
  localparam int unsigned ELEM_N     = 2 ** ELEM_W;
  localparam int unsigned TILE_CNT   = 2 ** TILE_W;

  // scale register; writes should land only while idle, a rule the user must keep, as the block does not enforce it
  logic [F32_W-1:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_data_i;
    end
  end

  // pipeline control: stage k moves when empty or stage k+1 moves
  logic [NST-1:0] valid_q;
  stage_en_t      adv;

  always_comb begin
    adv[NST-1] = !valid_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // slot tables, filled at elaboration: element part and tile part
  logic [ADDR_W-1:0] elem_lut [ELEM_N];
  logic [ADDR_W-1:0] tile_lut [TILE_CNT];

  for (genvar g = 0; g < ELEM_N; g++) begin : g_elem
    localparam int unsigned EV = (g / RUN_LEN) * RUN_STRIDE + (g % RUN_LEN);
    assign elem_lut[g] = ADDR_W'(EV);
  end

  for (genvar g = 0; g < TILE_CNT; g++) begin : g_tile
    localparam int unsigned TV = g * RUN_LEN;
    assign tile_lut[g] = ADDR_W'(TV);
  end

  // address rides alongside the float stages
  logic [ADDR_W-1:0] addr_q [NST];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      addr_q[0] <= elem_lut[element_index_i] + tile_lut[tile_index_i];
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        addr_q[k] <= addr_q[k-1];
      end
    end
  end

  srap_fp_pipe u_fp (
    .clk_i   (clk_i),
    .en_i    (adv),
    .scale_i (scale_q[F32_W-1:F32_W-BF_W]),
    .a_i     (a_value_i),
    .b_i     (b_value_i),
    .value_o (c_value_o)
  );

  assign out_valid_o = valid_q[NST-1];
  assign c_address_o = addr_q[NST-1];

  // input stalls only when every stage holds a request
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with an empty stage");

  // an accepted request appears in the first stage
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted request lost at stage one");

  // a free output never backs up the input
  a_no_false_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

endmodule
